/* src/skf_pkg.sv */
// shared types for the scalar kalman sample filter: control word fields,
// microcode program, register indexes and fixed constants
// no dependencies
package skf_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_THRESHOLD   = 2'd2;

    // fixed register widths
    localparam int COV_BITS    = 32;
    localparam int THRESH_BITS = 12;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd4050;

    // multiplier operand chunk, two chunks cover any operand
    localparam int CHUNK_BITS = 20;

    // program counter
    localparam int PC_BITS = 4;

    // datapath operation of a step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRED,
        OP_SETUP,
        OP_DIV,
        OP_EST,
        OP_COV,
        OP_OUT
    } seq_op_t;

    // shared multiplier operand select
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_K_DLO,
        MUL_K_DHI,
        MUL_NK_PLO,
        MUL_NK_PHI
    } mul_sel_t;

    // accumulator action
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    // sequencing of the program counter
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_NEXT_LOAD,
        JMP_LOOP,
        JMP_END
    } jmp_t;

    typedef struct packed {
        seq_op_t  op;
        mul_sel_t mul;
        acc_op_t  acc;
        jmp_t     jmp;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } seq_status_t;

    localparam ctl_t CTL_IDLE = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_HOLD, jmp: JMP_END};

    // microcode: predict, divide for the gain, update estimate, shrink covariance
    function automatic ctl_t skf_program(input logic [PC_BITS-1:0] pc);
        ctl_t w;
        w = CTL_IDLE;
        case (pc)
            4'd0:  w = '{op: OP_PRED,  mul: MUL_NONE,   acc: ACC_HOLD,   jmp: JMP_NEXT};
            4'd1:  w = '{op: OP_SETUP, mul: MUL_NONE,   acc: ACC_HOLD,   jmp: JMP_NEXT_LOAD};
            4'd2:  w = '{op: OP_DIV,   mul: MUL_NONE,   acc: ACC_HOLD,   jmp: JMP_LOOP};
            4'd3:  w = '{op: OP_NOP,   mul: MUL_K_DLO,  acc: ACC_HOLD,   jmp: JMP_NEXT};
            4'd4:  w = '{op: OP_NOP,   mul: MUL_K_DHI,  acc: ACC_LOAD,   jmp: JMP_NEXT};
            4'd5:  w = '{op: OP_NOP,   mul: MUL_NONE,   acc: ACC_ADD_HI, jmp: JMP_NEXT};
            4'd6:  w = '{op: OP_EST,   mul: MUL_NK_PLO, acc: ACC_HOLD,   jmp: JMP_NEXT};
            4'd7:  w = '{op: OP_NOP,   mul: MUL_NK_PHI, acc: ACC_LOAD,   jmp: JMP_NEXT};
            4'd8:  w = '{op: OP_NOP,   mul: MUL_NONE,   acc: ACC_ADD_HI, jmp: JMP_NEXT};
            4'd9:  w = '{op: OP_COV,   mul: MUL_NONE,   acc: ACC_HOLD,   jmp: JMP_NEXT};
            4'd10: w = '{op: OP_OUT,   mul: MUL_NONE,   acc: ACC_HOLD,   jmp: JMP_END};
            default: w = CTL_IDLE;
        endcase
        return w;
    endfunction

endpackage

/* src/skf_sequencer.sv */
// microcode sequencer: program counter, loop counter and busy flag,
// reads control words from the program in skf_pkg
// depends on skf_pkg
module skf_sequencer #(
    parameter int LOOP_COUNT = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  skf_pkg::seq_status_t status,
    output logic                busy,
    output skf_pkg::ctl_t       ctl
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(LOOP_COUNT);

    logic               busy_reg, busy_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // control word of the current step
    assign ctl  = busy_reg ? skf_program(pc_reg) : CTL_IDLE;
    assign busy = busy_reg;

    // next step selection
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg) begin
            if (status.start) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else begin
            case (ctl.jmp)
                JMP_NEXT: begin
                    pc_next = pc_reg + 1'b1;
                end
                JMP_NEXT_LOAD: begin
                    pc_next  = pc_reg + 1'b1;
                    cnt_next = CNT_W'(LOOP_COUNT - 1);
                end
                JMP_LOOP: begin
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                JMP_END: begin
                    if (status.out_free) begin
                        busy_next = 1'b0;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* src/scalar_kalman_sample_filter_unit.sv */
// scalar kalman sample filter top level: configuration registers, filter
// datapath with serial divider and shared multiplier, output register
// depends on skf_pkg and skf_sequencer
//
// Usage:
//   Input stream (s_*): one sample per transfer in s_tdata. The block takes a
//   sample only while no other sample is in work; s_tready drops for the
//   length of one update.
//   Output stream (m_*): one result per sample: estimate integer part, the
//   fixed-point estimate and the gain in m_tdata, the level flag in m_tuser.
//   A new sample is accepted in the cycle after the result is loaded. The
//   restoring divider for the gain takes one quotient bit a cycle; the two
//   products run in turn on one shared multiplier, each in two chunks.
//   A result waits in the output register while the receiver stalls; the
//   next sample is still accepted and runs until its result is ready, then
//   holds there until the output register frees.
//   Configuration (cfg_*): writes take effect at once; the user must write
//   only while idle, the block does not enforce it. Reset: estimate 0,
//   covariance 0.8, q 0.01, r 1.0, threshold 4050, both streams empty.
module scalar_kalman_sample_filter_unit #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [skf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [skf_pkg::COV_BITS-1:0]         cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // estimate_whole, estimate_fixed, gain
    output logic [((2*SAMPLE_BITS+2*FRACTION_BITS+1+7)/8)*8-1:0] m_tdata,
    output logic [0:0]                           m_tuser    // sample_high
);
    import skf_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int D      = S + F;
    localparam int OUT_W  = ((2*S + 2*F + 1 + 7) / 8) * 8;
    localparam int PAD_W  = 2 * CHUNK_BITS;
    localparam int PROD_W = F + 1 + CHUNK_BITS;
    localparam int ACC_W  = (S + 2*F + 1 > F + COV_BITS + 1) ? S + 2*F + 1
                                                            : F + COV_BITS + 1;
    localparam int THR_W  = (S < THRESH_BITS) ? S : THRESH_BITS;

    localparam longint ONE_L = longint'(1) << F;
    localparam logic [COV_BITS-1:0] Q_RESET = COV_BITS'((ONE_L + 50) / 100);
    localparam logic [COV_BITS-1:0] R_RESET = COV_BITS'(ONE_L);
    localparam logic [COV_BITS-1:0] P_RESET = COV_BITS'((8 * ONE_L + 5) / 10);
    localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};

    // sequencer
    ctl_t        ctl;
    seq_status_t status;
    logic        busy;
    logic        out_free;

    assign s_tready        = !busy;
    assign out_free        = !m_tvalid || m_tready;
    assign status.start    = s_tvalid && s_tready;
    assign status.out_free = out_free;

    skf_sequencer #(
        .LOOP_COUNT(F + 1)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .busy    (busy),
        .ctl     (ctl)
    );

    // configuration registers
    logic [COV_BITS-1:0]    q_reg, r_reg;
    logic [THRESH_BITS-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= Q_RESET;
            r_reg   <= R_RESET;
            thr_reg <= THRESH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROCESS_NOISE:     q_reg   <= cfg_data;
                REG_MEASUREMENT_NOISE: r_reg   <= cfg_data;
                REG_LEVEL_THRESHOLD:   thr_reg <= cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // filter state and working registers
    logic [D-1:0]        x_reg;
    logic [COV_BITS-1:0] p_reg;
    logic [S-1:0]        sample_reg;
    logic [COV_BITS-1:0] p1_reg;
    logic [COV_BITS:0]   den_reg;
    logic [COV_BITS+1:0] rem_reg;
    logic [F:0]          k_reg;
    logic [D-1:0]        diff_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;

    // prediction with saturation
    logic [COV_BITS:0]   pred_sum;
    logic [COV_BITS-1:0] pred_sat;

    assign pred_sum = {1'b0, p_reg} + {1'b0, q_reg};
    assign pred_sat = pred_sum[COV_BITS] ? '1 : pred_sum[COV_BITS-1:0];

    // measurement in estimate format and signed distance
    logic [D-1:0] z_val;
    logic         z_below;

    assign z_val   = {sample_reg, {F{1'b0}}};
    assign z_below = z_val < x_reg;

    // one restoring divide step
    logic                div_ge;
    logic [COV_BITS+1:0] div_sub;

    assign div_ge  = (rem_reg >= {1'b0, den_reg}) && (den_reg != '0);
    assign div_sub = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    // shared multiplier operands
    logic [PAD_W-1:0]      diff_pad, cov_pad;
    logic [F:0]            mul_a;
    logic [CHUNK_BITS-1:0] mul_b;

    assign diff_pad = PAD_W'(diff_reg);
    assign cov_pad  = PAD_W'(p1_reg);

    always_comb begin
        mul_a = k_reg;
        mul_b = '0;
        case (ctl.mul)
            MUL_K_DLO:  mul_b = diff_pad[CHUNK_BITS-1:0];
            MUL_K_DHI:  mul_b = diff_pad[PAD_W-1:CHUNK_BITS];
            MUL_NK_PLO: begin
                mul_a = GAIN_ONE - k_reg;
                mul_b = cov_pad[CHUNK_BITS-1:0];
            end
            MUL_NK_PHI: begin
                mul_a = GAIN_ONE - k_reg;
                mul_b = cov_pad[PAD_W-1:CHUNK_BITS];
            end
            default: mul_b = '0;
        endcase
    end

    // estimate step from the accumulated product
    logic [D-1:0] est_step;
    assign est_step = acc_reg[F +: D];

    // threshold limited to the sample width
    logic [S-1:0] thr_eff;
    assign thr_eff = S'(thr_reg[THR_W-1:0]);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            p_reg <= P_RESET;
        end else begin
            case (ctl.op)
                OP_EST:  x_reg <= neg_reg ? x_reg - est_step : x_reg + est_step;
                OP_COV:  p_reg <= acc_reg[F +: COV_BITS];
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (status.start) begin
            sample_reg <= s_tdata[S-1:0];
        end
        case (ctl.op)
            OP_PRED: begin
                p1_reg <= pred_sat;
            end
            OP_SETUP: begin
                den_reg  <= {1'b0, p1_reg} + {1'b0, r_reg};
                rem_reg  <= {2'b00, p1_reg};
                k_reg    <= '0;
                neg_reg  <= z_below;
                diff_reg <= z_below ? x_reg - z_val : z_val - x_reg;
            end
            OP_DIV: begin
                rem_reg <= {div_sub[COV_BITS:0], 1'b0};
                k_reg   <= {k_reg[F-1:0], div_ge};
            end
            default: ;
        endcase
        if (ctl.mul != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (ctl.acc)
            ACC_LOAD:   acc_reg <= ACC_W'(prod_reg);
            ACC_ADD_HI: acc_reg <= acc_reg + (ACC_W'(prod_reg) << CHUNK_BITS);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.op == OP_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == OP_OUT && out_free) begin
            m_tdata_reg <= OUT_W'({k_reg, x_reg, x_reg[D-1:F]});
            m_tuser_reg <= sample_reg >= thr_eff;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
